@@ rtl/core/mcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared types and constants of the memory code chip generator.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  // code memory depth, a power of two so that fetch addresses wrap naturally
  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);

  localparam int OP_W       = 2;
  localparam int MADDR_W    = 12;
  localparam int WORD_W     = 32;
  localparam int BLOCK_W    = 7;
  localparam int SEGS_W     = 4;
  localparam int COUNT_W    = 14;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int SEG_BITS   = 10;
  localparam int WORDIDX_W  = COUNT_W - BIT_W;
  localparam int FETCH_W    = BLOCK_W + BIT_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BLOCK_W;

  localparam logic [SEG_BITS-1:0] SEG_LAST = 10'h3ff;
  localparam logic [BIT_W-1:0]    BIT_MSB  = 5'h1f;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTART = 2'd1,
    OP_SHIFT   = 2'd2,
    OP_NONE    = 2'd3
  } op_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BLOCK   = 1'd0,
    CFG_SEGMENT_COUNT = 1'd1
  } cfg_idx_t;

  // item in flight between the memory read and the output register
  typedef struct packed {
    logic             fetch;
    logic             wrap;
    logic [BIT_W-1:0] bit_idx;
  } stage_t;

endpackage

@@ rtl/core/mcpg_if.sv @@
// ----------------------------------------------------------------------------
// mcpg channel interfaces
// Command, chip result and configuration write channels.
// ----------------------------------------------------------------------------
interface mcpg_cmd_if import mcpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [MADDR_W-1:0] mem_address;
  logic [WORD_W-1:0]  mem_data;

  modport source (output valid, op, mem_address, mem_data, input ready);
  modport sink   (input valid, op, mem_address, mem_data, output ready);
endinterface

interface mcpg_chip_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic new_round;

  modport source (output valid, code_bit, new_round, input ready);
  modport sink   (input valid, code_bit, new_round, output ready);
endinterface

interface mcpg_cfg_if import mcpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/mcpg_code_ram.sv @@
// ----------------------------------------------------------------------------
// mcpg_code_ram
// Code word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcpg_code_ram import mcpg_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/memory_code_prn_generator.sv @@
// ----------------------------------------------------------------------------
// memory_code_prn_generator
// Spreading-code chip generator playing a code stored in a word memory.
// ----------------------------------------------------------------------------
// Channels: cmd takes items (write a code word, restart the phase, shift one
// chip); chip returns one item per command with the current code chip and a
// new_round flag set when a shift wraps the code to its start. cfg writes
// start_block (index 0) and segment_count (index 1); both are sampled at a
// restart. Write cfg only while no command is in flight.
// Path: a command's result is registered by the synchronous code memory read
// and the middle stage, then by the output register. Throughput: one command
// per cycle while chip.ready is high, set by the single read port of the code
// memory, which fetches at most one word per command; a word boundary is
// fetched as the command is accepted and the word lands in the output stage.
// Reset clears the chip count, the held word, the latched configuration and
// both pipeline stages; the code memory is not cleared and must be written
// before it is played. When chip.ready is low the output holds, the middle
// stage fills, and then cmd.ready drops until the output is taken.
// ----------------------------------------------------------------------------
module memory_code_prn_generator import mcpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mcpg_cmd_if.sink    cmd,
  mcpg_chip_if.source chip,
  mcpg_cfg_if.sink    cfg
);

  logic [BLOCK_W-1:0] start_block;
  logic [SEGS_W-1:0]  segment_count;
  logic [BLOCK_W-1:0] held_block;
  logic [BLOCK_W-1:0] held_block_next;
  logic [SEGS_W-1:0]  held_segments;
  logic [SEGS_W-1:0]  held_segments_next;
  logic [COUNT_W-1:0] chip_count;
  logic [COUNT_W-1:0] chip_count_next;
  logic               wrap_next;
  logic               fetch_next;

  logic              s1_valid;
  stage_t            s1;
  logic              s1_move;
  logic              cmd_acc;
  logic              cfg_acc;
  logic [WORD_W-1:0] current_word;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] word_sel;
  logic [FETCH_W-1:0] fetch_sum;
  logic              out_valid;
  logic              out_bit;
  logic              out_wrap;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid;
  assign s1_move   = s1_valid && (!out_valid || chip.ready);
  assign cmd.ready = !s1_valid || s1_move;
  assign cmd_acc   = cmd.valid && cmd.ready;

  // count update and fetch decision for the incoming command
  always_comb begin
    logic [COUNT_W-1:0] step;
    held_block_next    = held_block;
    held_segments_next = held_segments;
    chip_count_next    = chip_count;
    wrap_next          = 1'b0;
    fetch_next         = 1'b0;
    step               = chip_count + COUNT_W'(1);
    unique case (op_e_t'(cmd.op))
      OP_RESTART: begin
        held_block_next    = start_block;
        held_segments_next = segment_count;
        chip_count_next    = '0;
        fetch_next         = 1'b1;
      end
      OP_SHIFT: begin
        if (step[SEG_BITS-1:0] == SEG_LAST) begin
          // skip the unused last chip of the segment
          step = step + COUNT_W'(1);
          if (step[COUNT_W-1:SEG_BITS] == held_segments) begin
            step      = '0;
            wrap_next = 1'b1;
          end
        end
        chip_count_next = step;
        fetch_next      = (step[BIT_W-1:0] == '0);
      end
      default: begin
      end
    endcase
  end

  assign fetch_sum = {1'b0, held_block_next, {BIT_W{1'b0}}}
                   + FETCH_W'(chip_count_next[COUNT_W-1:BIT_W]);

  mcpg_code_ram u_ram (
    .clk   (clk),
    .we    (cmd_acc && (op_e_t'(cmd.op) == OP_WRITE)),
    .waddr (cmd.mem_address[ADDR_W-1:0]),
    .wdata (cmd.mem_data),
    .re    (cmd_acc && fetch_next),
    .raddr (fetch_sum[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign word_sel = s1.fetch ? rdata : current_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_block   <= '0;
      segment_count <= '0;
      held_block    <= '0;
      held_segments <= '0;
      chip_count    <= '0;
      current_word  <= '0;
      s1_valid      <= 1'b0;
      s1            <= '0;
      out_valid     <= 1'b0;
      out_bit       <= 1'b0;
      out_wrap      <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_idx_t'(cfg.index))
          CFG_START_BLOCK:   start_block   <= cfg.data;
          CFG_SEGMENT_COUNT: segment_count <= cfg.data[SEGS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_acc) begin
        held_block    <= held_block_next;
        held_segments <= held_segments_next;
        chip_count    <= chip_count_next;
        s1.fetch      <= fetch_next;
        s1.wrap       <= wrap_next;
        s1.bit_idx    <= chip_count_next[BIT_W-1:0];
        s1_valid      <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
        out_bit   <= word_sel[BIT_MSB - s1.bit_idx];
        out_wrap  <= s1.wrap;
        if (s1.fetch) begin
          current_word <= rdata;
        end
      end else if (chip.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign chip.valid     = out_valid;
  assign chip.code_bit  = out_bit;
  assign chip.new_round = out_wrap;

  // the unused last chip of a segment is never the current position
  a_no_last_chip: assert property (@(posedge clk) disable iff (rst)
    chip_count[SEG_BITS-1:0] != SEG_LAST)
    else $error("chip count sits on the skipped chip");

  // a wrap always brings a fetch of the first word
  a_wrap_fetch: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1.wrap |-> s1.fetch)
    else $error("wrap without word fetch");

  // an accepted wrapping shift leaves the count at zero
  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    cmd_acc && wrap_next |=> chip_count == '0)
    else $error("count not cleared after wrap");

  // with an empty output register the block always takes a command
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> cmd.ready)
    else $error("command stalled with empty output");

endmodule

@@ bench/mcpg_chip_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpg_chip_checker
// Watches the command, chip and configuration channels of the chip generator,
// keeps its own copy of the code memory and play state, and compares every
// chip item against the predicted chip and new_round flag in order.
// ----------------------------------------------------------------------------
module mcpg_chip_checker import mcpg_pkg::*; (
  input  logic clk,
  input  logic rst,
  mcpg_cmd_if  cmd,
  mcpg_chip_if chip,
  mcpg_cfg_if  cfg,
  output int   failures,
  output int   pending,
  output int   chips_checked,
  output int   rounds_seen
);

  typedef struct packed {
    logic code_bit;
    logic new_round;
  } chip_t;

  chip_t expected_chips[$];

  logic [WORD_W-1:0]  code_mem [MEM_WORDS];
  logic [WORD_W-1:0]  play_word;
  logic [COUNT_W-1:0] play_count;
  logic [BLOCK_W-1:0] cfg_block;
  logic [BLOCK_W-1:0] held_block;
  logic [SEGS_W-1:0]  cfg_segs;
  logic [SEGS_W-1:0]  held_segs;

  // advance the play state by one command item and give the chip it shows
  task automatic step_code(input logic [OP_W-1:0] op, input logic [MADDR_W-1:0] addr,
                           input logic [WORD_W-1:0] data, output chip_t res);
    logic [COUNT_W-1:0] c;
    logic [ADDR_W-1:0]  fa;
    logic               wrap;
    wrap = 1'b0;
    case (op_e_t'(op))
      OP_WRITE: begin
        code_mem[addr] = data;
      end
      OP_RESTART: begin
        held_block = cfg_block;
        held_segs  = cfg_segs;
        play_count = '0;
        fa         = {held_block, {BIT_W{1'b0}}};
        play_word  = code_mem[fa];
      end
      OP_SHIFT: begin
        c = play_count + COUNT_W'(1);
        if (c[SEG_BITS-1:0] == SEG_LAST) begin
          // last chip of a segment is never played
          c = c + COUNT_W'(1);
          if (c[COUNT_W-1:SEG_BITS] == held_segs) begin
            c    = '0;
            wrap = 1'b1;
          end
        end
        play_count = c;
        if (c[BIT_W-1:0] == '0) begin
          fa        = {held_block, {BIT_W{1'b0}}} + ADDR_W'(c[COUNT_W-1:BIT_W]);
          play_word = code_mem[fa];
        end
      end
      default: ;
    endcase
    res.code_bit  = play_word[BIT_MSB - play_count[BIT_W-1:0]];
    res.new_round = wrap;
  endtask

  always @(posedge clk) begin
    chip_t got;
    chip_t want;
    if (rst) begin
      expected_chips.delete();
      play_word     = '0;
      play_count    = '0;
      cfg_block     = '0;
      held_block    = '0;
      cfg_segs      = '0;
      held_segs     = '0;
      failures      = 0;
      pending       = 0;
      chips_checked = 0;
      rounds_seen   = 0;
    end else begin
      if (chip.valid && chip.ready) begin
        got.code_bit  = chip.code_bit;
        got.new_round = chip.new_round;
        chips_checked++;
        if (expected_chips.size() == 0) begin
          $error("chip item with no command waiting: code_bit %0b new_round %0b",
                 got.code_bit, got.new_round);
          failures++;
        end else begin
          want = expected_chips.pop_front();
          if (got.code_bit !== want.code_bit) begin
            $error("code_bit mismatch: expected %0b, actual %0b", want.code_bit, got.code_bit);
            failures++;
          end
          if (got.new_round !== want.new_round) begin
            $error("new_round mismatch: expected %0b, actual %0b",
                   want.new_round, got.new_round);
            failures++;
          end
          if (want.new_round) rounds_seen++;
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_START_BLOCK:   cfg_block = cfg.data[BLOCK_W-1:0];
          CFG_SEGMENT_COUNT: cfg_segs  = cfg.data[SEGS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        step_code(cmd.op, cmd.mem_address, cmd.mem_data, want);
        expected_chips.push_back(want);
      end
      pending = expected_chips.size();
    end
  end

endmodule

@@ bench/tb_memory_code_prn_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_memory_code_prn_generator
// Drives code word writes, restarts and chip shifts into the chip generator
// under random idling on both sides, steering every fetch onto written words,
// and lets the checker compare each chip item. A long run walks a whole round.
// ----------------------------------------------------------------------------
module tb_memory_code_prn_generator import mcpg_pkg::*; ();

  localparam int IDLE_PCT     = 34;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 300;

  logic clk;
  logic rst;
  bit   no_idle;
  int   items_sent;
  int   failures;
  int   pending;
  int   chips_checked;
  int   rounds_seen;
  int   stall_cycles;

  // stimulus side view of the play position, used to keep fetches on written words
  bit                 written [MEM_WORDS];
  logic [BLOCK_W-1:0] cfg_block;
  logic [BLOCK_W-1:0] run_block;
  logic [SEGS_W-1:0]  cfg_segs;
  logic [SEGS_W-1:0]  run_segs;
  logic [COUNT_W-1:0] run_count;

  mcpg_cmd_if  cmd ();
  mcpg_chip_if chip ();
  mcpg_cfg_if  cfg ();

  memory_code_prn_generator u_top (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .chip (chip),
    .cfg  (cfg)
  );

  mcpg_chip_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .chip          (chip),
    .cfg           (cfg),
    .failures      (failures),
    .pending       (pending),
    .chips_checked (chips_checked),
    .rounds_seen   (rounds_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    chip.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (chip.valid && chip.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles", stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_command(input op_e_t op, input logic [MADDR_W-1:0] addr,
                              input logic [WORD_W-1:0] data);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.op          <= op;
    cmd.mem_address <= addr;
    cmd.mem_data    <= data;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic fill_word(input logic [ADDR_W-1:0] fa);
    written[fa] = 1'b1;
    push_command(OP_WRITE, fa, $urandom());
  endtask

  // sends one item, first writing any word that the item would fetch unwritten
  task automatic play_op(input op_e_t op, input logic [MADDR_W-1:0] addr,
                         input logic [WORD_W-1:0] data);
    logic [COUNT_W-1:0] c;
    logic [ADDR_W-1:0]  fa;
    case (op)
      OP_WRITE: begin
        written[addr] = 1'b1;
      end
      OP_RESTART: begin
        fa = {cfg_block, {BIT_W{1'b0}}};
        if (!written[fa]) fill_word(fa);
        run_block = cfg_block;
        run_segs  = cfg_segs;
        run_count = '0;
      end
      OP_SHIFT: begin
        c = run_count + COUNT_W'(1);
        if (c[SEG_BITS-1:0] == SEG_LAST) begin
          c = c + COUNT_W'(1);
          if (c[COUNT_W-1:SEG_BITS] == run_segs) c = '0;
        end
        if (c[BIT_W-1:0] == '0) begin
          fa = {run_block, {BIT_W{1'b0}}} + ADDR_W'(c[COUNT_W-1:BIT_W]);
          if (!written[fa]) fill_word(fa);
        end
        run_count = c;
      end
      default: ;
    endcase
    push_command(op, addr, data);
  endtask

  task automatic drain_chips();
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic load_code_setup(input logic [BLOCK_W-1:0] block, input logic [SEGS_W-1:0] segs);
    logic [CFG_DATA_W-1:0] value;
    drain_chips();
    write_reg(CFG_START_BLOCK, block);
    // upper data bits are junk for the segment register
    value              = CFG_DATA_W'($urandom_range(127));
    value[SEGS_W-1:0]  = segs;
    write_reg(CFG_SEGMENT_COUNT, value);
    cfg_block = block;
    cfg_segs  = segs;
  endtask

  // restart and shift through whole rounds with a little noise mixed in
  task automatic long_round(input logic [BLOCK_W-1:0] block, input logic [SEGS_W-1:0] segs,
                            input int rounds, input bit quiet);
    int n;
    int r;
    n = ((segs == 0) ? 16 : segs) * 1023 * rounds + $urandom_range(40, 300);
    load_code_setup(block, segs);
    no_idle = quiet;
    play_op(OP_RESTART, MADDR_W'($urandom()), $urandom());
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 2)      play_op(OP_WRITE, MADDR_W'($urandom()), $urandom());
      else if (r < 4) play_op(OP_NONE, MADDR_W'($urandom()), $urandom());
      else            play_op(OP_SHIFT, MADDR_W'($urandom()), $urandom());
    end
    drain_chips();
    no_idle = 1'b0;
  endtask

  initial begin
    int                 goal;
    int                 n;
    int                 r;
    logic [BLOCK_W-1:0] block;
    logic [SEGS_W-1:0]  segs;
    logic [ADDR_W-1:0]  fa;

    rst             = 1'b1;
    no_idle         = 1'b0;
    items_sent      = 0;
    stall_cycles    = 0;
    cmd.valid       = 1'b0;
    cmd.op          = OP_NONE;
    cmd.mem_address = '0;
    cmd.mem_data    = '0;
    cfg.valid       = 1'b0;
    cfg.index       = CFG_START_BLOCK;
    cfg.data        = '0;
    chip.ready      = 1'b0;
    cfg_block       = '0;
    cfg_segs        = '0;
    run_block       = '0;
    run_segs        = '0;
    run_count       = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: items before any restart, extremes, and writes to the played word
    play_op(OP_NONE, '0, '0);
    play_op(OP_SHIFT, '0, '0);
    load_code_setup('0, 4'd1);
    play_op(OP_WRITE, 12'h000, 32'h8000_0001);
    play_op(OP_WRITE, 12'hfff, 32'hffff_ffff);
    play_op(OP_WRITE, 12'h001, 32'h0000_0000);
    play_op(OP_RESTART, '0, '0);
    play_op(OP_SHIFT, '0, '0);
    play_op(OP_NONE, 12'hfff, 32'hffff_ffff);
    play_op(OP_WRITE, 12'h000, 32'h0000_0000);
    repeat (3) play_op(OP_SHIFT, '0, '0);
    play_op(OP_WRITE, 12'h000, 32'h7fff_ffff);
    play_op(OP_RESTART, '0, '0);
    play_op(OP_RESTART, '0, '0);
    play_op(OP_SHIFT, '0, '0);
    load_code_setup(7'd127, 4'd0);
    play_op(OP_SHIFT, '0, '0);
    play_op(OP_RESTART, '0, '0);
    repeat (3) play_op(OP_SHIFT, '0, '0);
    play_op(OP_WRITE, 12'hfe0, 32'hffff_ffff);
    play_op(OP_SHIFT, '0, '0);

    // random phases of mixed items under random configuration
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      r = $urandom_range(3);
      block = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(127));
      r = $urandom_range(2);
      segs = (r == 0) ? 4'd1 : (r == 1) ? 4'd2 : 4'($urandom_range(15));
      load_code_setup(block, segs);
      // a few shifts on the old setting before the new one is latched
      if ($urandom_range(9) < 3) begin
        repeat ($urandom_range(1, 8)) play_op(OP_SHIFT, MADDR_W'($urandom()), $urandom());
      end
      play_op(OP_RESTART, MADDR_W'($urandom()), $urandom());
      n = $urandom_range(40, 200);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(99);
        if (r < 62) begin
          play_op(OP_SHIFT, MADDR_W'($urandom()), $urandom());
        end else if (r < 74) begin
          play_op(OP_WRITE, MADDR_W'($urandom()), $urandom());
        end else if (r < 80) begin
          // hit the word being played or the one to be fetched next
          fa = {run_block, {BIT_W{1'b0}}} + ADDR_W'(run_count[COUNT_W-1:BIT_W]) +
               ADDR_W'($urandom_range(1));
          play_op(OP_WRITE, fa, $urandom());
        end else if (r < 88) begin
          play_op(OP_RESTART, MADDR_W'($urandom()), $urandom());
        end else if (r < 94) begin
          play_op(OP_NONE, MADDR_W'($urandom()), $urandom());
        end else begin
          play_op(OP_WRITE, MADDR_W'($urandom()),
                  ($urandom_range(1) != 0) ? 32'hffff_ffff : 32'h0);
        end
      end
    end

    // one whole one-segment round and into the next, with no idling
    long_round(7'($urandom_range(127)), 4'd1, 1, 1'b1);

    drain_chips();
    repeat (4) @(negedge clk);
    $display("sent %0d command items over start blocks 0 to 127 and 1 to 16 segments",
             items_sent);
    $display("checked %0d chips, %0d code rounds wrapped, %0d mismatches",
             chips_checked, rounds_seen, failures);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
